// ===== src/msrs_pkg.sv =====
// shared widths, codes and stage types of the max-step ray/sphere solver
`default_nettype none
package msrs_pkg;

  // fixed field widths
  localparam int unsigned CoordW  = 32;
  localparam int unsigned CfgW    = 31;
  localparam int unsigned PointW  = 33;  // start point after flip
  localparam int unsigned PsumW   = 48;  // sum of squared start coordinates
  localparam int unsigned DotW    = 34;  // rounded projection d
  localparam int unsigned QW      = 51;  // signed quarter discriminant
  localparam int unsigned QuoW    = 31;  // magnitude of one unit component

  // chain lengths
  localparam int unsigned RootW     = 32;  // both square roots give 32 bits
  localparam int unsigned NormCells = RootW;
  localparam int unsigned DivCells  = QuoW;
  localparam int unsigned RootCells = RootW;
  localparam int unsigned Lanes     = 3;

  // quarter discriminant limits (4q <= 64 is tangent)
  localparam logic signed [QW-1:0] QTangentMax = QW'(16);
  localparam int unsigned QLimitLog2 = 47;

  // config register indexes and reset value
  localparam logic RegMaxStep = 1'b0;
  localparam logic RegRotScale = 1'b1;
  localparam logic [CfgW-1:0] CfgReset = CfgW'(65536);

  // root kind codes
  localparam logic [1:0] KindNone    = 2'd0;
  localparam logic [1:0] KindTangent = 2'd1;
  localparam logic [1:0] KindTwo     = 2'd2;
  localparam logic [1:0] KindZeroDir = 2'd3;

  // data riding along the norm square-root chain
  typedef struct packed {
    logic [Lanes-1:0][PointW-1:0] p;
    logic [Lanes-1:0]             hneg;
    logic [Lanes-1:0][CoordW-1:0] hmag;
    logic [PsumW-1:0]             psum;
    logic                         zero;
  } norm_side_t;

  // data riding along the divider chain
  typedef struct packed {
    logic [Lanes-1:0][PointW-1:0] p;
    logic [Lanes-1:0]             hneg;
    logic [PsumW-1:0]             psum;
    logic                         zero;
  } div_side_t;

  // data riding along the final square-root chain
  typedef struct packed {
    logic [DotW-1:0] d;
    logic [1:0]      kind;
  } root_side_t;

endpackage
`default_nettype wire

// ===== src/max_step_ray_sphere_solver.sv =====
// Max-step ray/sphere solver: step length along a unit heading to a sphere.
// Input channel: in_valid_i / in_stall_o carry start point, heading and flip flag;
// a transfer happens at a clock edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i carry step_length_o and root_kind_o,
// one result per input item, in input order.
// Config: APB-style port; register 0 (byte address 0) is the sphere radius,
// register 1 (byte address 4) the yaw scale, both Q16.16 unsigned, reset 1.0.
// Write them only while no item is in flight.
// Pipeline: 5 front stages, 32 norm square-root cells, 31 divider cells, 6 back stages,
// 32 square-root cells for the discriminant and the output register.
// Throughput: one item per cycle while the chain advances, each cell handing its item on.
// While the receiver stalls with a result waiting, the pipeline still advances
// until its last cell holds an item, then the whole chain freezes and in_stall_o
// rises; empty slots ahead of the stall are filled meanwhile.
// Reset clears all valid flags and sets both config registers to 1.0.
`default_nettype none
module max_step_ray_sphere_solver
  import msrs_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // config port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  // input channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic signed [31:0]  start_x_i,
  input  wire logic signed [31:0]  start_y_i,
  input  wire logic signed [31:0]  start_yaw_i,
  input  wire logic signed [31:0]  heading_x_i,
  input  wire logic signed [31:0]  heading_y_i,
  input  wire logic signed [31:0]  heading_yaw_i,
  input  wire logic                flip_group_i,
  // output channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic signed [31:0]       step_length_o,
  output logic [1:0]               root_kind_o
);

  localparam int unsigned NormSW = $bits(norm_side_t);
  localparam int unsigned DivSW  = $bits(div_side_t);
  localparam int unsigned RootSW = $bits(root_side_t);

  // ---------------- config registers ----------------
  logic [CfgW-1:0] max_step_q, rot_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_step_q  <= CfgReset;
      rot_scale_q <= CfgReset;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == RegMaxStep) begin
        max_step_q <= pwdata[CfgW-1:0];
      end else begin
        rot_scale_q <= pwdata[CfgW-1:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegRotScale) ? {1'b0, rot_scale_q} : {1'b0, max_step_q};

  // ---------------- flow control ----------------
  logic adv, out_load;
  logic last_valid;
  logic out_valid_q;

  assign out_load   = !out_valid_q || !out_stall_i;
  assign adv        = out_load || !last_valid;
  assign in_stall_o = !adv;

  // ---------------- F1: input capture ----------------
  logic                          f1_valid_q;
  logic [CoordW-1:0]             f1_sx_q, f1_sy_q, f1_syaw_q;
  logic [Lanes-1:0][CoordW-1:0]  f1_h_q;
  logic                          f1_flip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else if (adv) begin
      f1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_sx_q   <= start_x_i;
      f1_sy_q   <= start_y_i;
      f1_syaw_q <= start_yaw_i;
      f1_h_q    <= {heading_yaw_i, heading_y_i, heading_x_i};
      f1_flip_q <= flip_group_i;
    end
  end

  // ---------------- F2: yaw scaling and heading squares ----------------
  logic                          f2_valid_q;
  logic signed [62:0]            f2_yprod_d, f2_yprod_q;
  logic [Lanes-1:0][CoordW-1:0]  f2_hmag_d, f2_hmag_q;
  logic [Lanes-1:0][63:0]        f2_hsq_d, f2_hsq_q;
  logic [Lanes-1:0]              f2_hneg_q;
  logic [CoordW-1:0]             f2_sx_q, f2_sy_q;
  logic                          f2_flip_q;

  always_comb begin
    f2_yprod_d = $signed(f1_syaw_q) * $signed({1'b0, rot_scale_q});
    for (int l = 0; l < Lanes; l++) begin
      f2_hmag_d[l] = f1_h_q[l][CoordW-1] ? (~f1_h_q[l] + 32'd1) : f1_h_q[l];
      f2_hsq_d[l]  = {32'd0, f2_hmag_d[l]} * {32'd0, f2_hmag_d[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f2_valid_q <= 1'b0;
    end else if (adv) begin
      f2_valid_q <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f2_yprod_q <= f2_yprod_d;
      f2_hmag_q  <= f2_hmag_d;
      f2_hsq_q   <= f2_hsq_d;
      for (int l = 0; l < Lanes; l++) begin
        f2_hneg_q[l] <= f1_h_q[l][CoordW-1];
      end
      f2_sx_q   <= f1_sx_q;
      f2_sy_q   <= f1_sy_q;
      f2_flip_q <= f1_flip_q;
    end
  end

  // ---------------- F3: heading length squared, start point ----------------
  logic                          f3_valid_q;
  logic [63:0]                   f3_hh_q;
  logic [Lanes-1:0][PointW-1:0]  f3_p_d, f3_p_q;
  logic [Lanes-1:0][CoordW-1:0]  f3_hmag_q;
  logic [Lanes-1:0]              f3_hneg_q;
  logic [46:0]                   f3_ysh;
  logic [CoordW-1:0]             f3_yaw;

  // floor shift to Q16.16 and clamp to int32
  always_comb begin
    f3_ysh = f2_yprod_q[62:16];
    if (!f3_ysh[46] && (f3_ysh[45:31] != '0)) begin
      f3_yaw = 32'h7FFF_FFFF;
    end else if (f3_ysh[46] && (f3_ysh[45:31] != '1)) begin
      f3_yaw = 32'h8000_0000;
    end else begin
      f3_yaw = f3_ysh[31:0];
    end
    f3_p_d[0] = {f2_sx_q[CoordW-1], f2_sx_q};
    f3_p_d[1] = {f2_sy_q[CoordW-1], f2_sy_q};
    f3_p_d[2] = {f3_yaw[CoordW-1], f3_yaw};
    if (f2_flip_q) begin
      for (int l = 0; l < Lanes; l++) begin
        f3_p_d[l] = ~f3_p_d[l] + 33'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f3_valid_q <= 1'b0;
    end else if (adv) begin
      f3_valid_q <= f2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f3_hh_q   <= f2_hsq_q[0] + f2_hsq_q[1] + f2_hsq_q[2];
      f3_p_q    <= f3_p_d;
      f3_hmag_q <= f2_hmag_q;
      f3_hneg_q <= f2_hneg_q;
    end
  end

  // ---------------- F4: start point squares ----------------
  logic                          f4_valid_q;
  logic [63:0]                   f4_hh_q;
  logic [Lanes-1:0][PointW-1:0]  f4_p_q;
  logic [Lanes-1:0][CoordW-1:0]  f4_hmag_q;
  logic [Lanes-1:0]              f4_hneg_q;
  logic [Lanes-1:0][46:0]        f4_psq_d, f4_psq_q;
  logic [Lanes-1:0][PointW-1:0]  f4_pabs;
  logic [Lanes-1:0][63:0]        f4_pprod;

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      f4_pabs[l]  = f3_p_q[l][PointW-1] ? (~f3_p_q[l] + 33'd1) : f3_p_q[l];
      f4_pprod[l] = {32'd0, f4_pabs[l][31:0]} * {32'd0, f4_pabs[l][31:0]};
      f4_psq_d[l] = f4_pprod[l][62:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f4_valid_q <= 1'b0;
    end else if (adv) begin
      f4_valid_q <= f3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f4_hh_q   <= f3_hh_q;
      f4_p_q    <= f3_p_q;
      f4_hmag_q <= f3_hmag_q;
      f4_hneg_q <= f3_hneg_q;
      f4_psq_q  <= f4_psq_d;
    end
  end

  // ---------------- F5: sum of squares, zero heading check ----------------
  logic        f5_valid_q;
  logic [63:0] f5_hh_q;
  norm_side_t  f5_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f5_valid_q <= 1'b0;
    end else if (adv) begin
      f5_valid_q <= f4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f5_hh_q        <= f4_hh_q;
      f5_side_q.p    <= f4_p_q;
      f5_side_q.hneg <= f4_hneg_q;
      f5_side_q.hmag <= f4_hmag_q;
      f5_side_q.psum <= {1'b0, f4_psq_q[0]} + {1'b0, f4_psq_q[1]} + {1'b0, f4_psq_q[2]};
      f5_side_q.zero <= (f4_hh_q == '0);
    end
  end

  // ---------------- norm square-root chain ----------------
  logic [NormCells:0]               n_valid;
  logic [NormCells:0][2*RootW-1:0]  n_rad;
  logic [NormCells:0][RootW+1:0]    n_rem;
  logic [NormCells:0][RootW-1:0]    n_root;
  logic [NormCells:0][NormSW-1:0]   n_side;

  assign n_valid[0] = f5_valid_q;
  assign n_rad[0]   = f5_hh_q;
  assign n_rem[0]   = '0;
  assign n_root[0]  = '0;
  assign n_side[0]  = f5_side_q;

  for (genvar k = 0; k < NormCells; k++) begin : g_norm
    msrs_sqrt_cell #(
      .RW (RootW),
      .SW (NormSW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (n_valid[k]),
      .rad_i   (n_rad[k]),
      .rem_i   (n_rem[k]),
      .root_i  (n_root[k]),
      .side_i  (n_side[k]),
      .valid_o (n_valid[k+1]),
      .rad_o   (n_rad[k+1]),
      .rem_o   (n_rem[k+1]),
      .root_o  (n_root[k+1]),
      .side_o  (n_side[k+1])
    );
  end

  // ---------------- divider chain: unit heading components ----------------
  norm_side_t n_last;
  div_side_t  dv_in_side;

  logic [DivCells:0]                         dv_valid;
  logic [DivCells:0][CoordW-1:0]             dv_div;
  logic [DivCells:0][Lanes-1:0][CoordW-1:0]  dv_rem;
  logic [DivCells:0][Lanes-1:0][QuoW-1:0]    dv_num;
  logic [DivCells:0][Lanes-1:0][QuoW-1:0]    dv_quo;
  logic [DivCells:0][DivSW-1:0]              dv_side;

  // numerator is |h| * 2^30; its top part already below the norm
  always_comb begin
    n_last          = norm_side_t'(n_side[NormCells]);
    dv_in_side.p    = n_last.p;
    dv_in_side.hneg = n_last.hneg;
    dv_in_side.psum = n_last.psum;
    dv_in_side.zero = n_last.zero;
    for (int l = 0; l < Lanes; l++) begin
      dv_rem[0][l] = {1'b0, n_last.hmag[l][CoordW-1:1]};
      dv_num[0][l] = {n_last.hmag[l][0], {(QuoW-1){1'b0}}};
      dv_quo[0][l] = '0;
    end
  end

  assign dv_valid[0] = n_valid[NormCells];
  assign dv_div[0]   = n_root[NormCells];
  assign dv_side[0]  = dv_in_side;

  for (genvar k = 0; k < DivCells; k++) begin : g_div
    msrs_div_cell #(
      .DW (CoordW),
      .QB (QuoW),
      .LN (Lanes),
      .SW (DivSW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (dv_valid[k]),
      .div_i   (dv_div[k]),
      .rem_i   (dv_rem[k]),
      .num_i   (dv_num[k]),
      .quo_i   (dv_quo[k]),
      .side_i  (dv_side[k]),
      .valid_o (dv_valid[k+1]),
      .div_o   (dv_div[k+1]),
      .rem_o   (dv_rem[k+1]),
      .num_o   (dv_num[k+1]),
      .quo_o   (dv_quo[k+1]),
      .side_o  (dv_side[k+1])
    );
  end

  // ---------------- B1: signed unit components ----------------
  div_side_t                     dv_last;
  logic                          b1_valid_q;
  logic [Lanes-1:0][CoordW-1:0]  b1_u_d, b1_u_q;
  logic [Lanes-1:0][PointW-1:0]  b1_p_q;
  logic [PsumW-1:0]              b1_psum_q;
  logic                          b1_zero_q;

  always_comb begin
    dv_last = div_side_t'(dv_side[DivCells]);
    for (int l = 0; l < Lanes; l++) begin
      b1_u_d[l] = dv_last.hneg[l] ? (~{1'b0, dv_quo[DivCells][l]} + 32'd1)
                                  : {1'b0, dv_quo[DivCells][l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
    end else if (adv) begin
      b1_valid_q <= dv_valid[DivCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_u_q    <= b1_u_d;
      b1_p_q    <= dv_last.p;
      b1_psum_q <= dv_last.psum;
      b1_zero_q <= dv_last.zero;
    end
  end

  // ---------------- B2: projection products ----------------
  logic                      b2_valid_q;
  logic [Lanes-1:0][64:0]    b2_full;
  logic [Lanes-1:0][63:0]    b2_prod_q;
  logic [PsumW-1:0]          b2_psum_q;
  logic                      b2_zero_q;

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      b2_full[l] = $signed(b1_p_q[l]) * $signed(b1_u_q[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b2_valid_q <= 1'b0;
    end else if (adv) begin
      b2_valid_q <= b1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < Lanes; l++) begin
        b2_prod_q[l] <= b2_full[l][63:0];
      end
      b2_psum_q <= b1_psum_q;
      b2_zero_q <= b1_zero_q;
    end
  end

  // ---------------- B3: dot product rounded to Q16.16 ----------------
  logic              b3_valid_q;
  logic [63:0]       b3_dot;
  logic [DotW-1:0]   b3_d_q;
  logic [PsumW-1:0]  b3_psum_q;
  logic              b3_zero_q;

  assign b3_dot = b2_prod_q[0] + b2_prod_q[1] + b2_prod_q[2] + 64'(1 << 29);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b3_valid_q <= 1'b0;
    end else if (adv) begin
      b3_valid_q <= b2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b3_d_q    <= b3_dot[63:30];
      b3_psum_q <= b2_psum_q;
      b3_zero_q <= b2_zero_q;
    end
  end

  // ---------------- B4: d squared and radius squared ----------------
  logic              b4_valid_q;
  logic [DotW-1:0]   b4_dabs;
  logic [65:0]       b4_dprod;
  logic [61:0]       b4_rprod;
  logic [47:0]       b4_dsq_q;
  logic [45:0]       b4_rsq_q;
  logic [DotW-1:0]   b4_d_q;
  logic [PsumW-1:0]  b4_psum_q;
  logic              b4_zero_q;

  always_comb begin
    b4_dabs  = b3_d_q[DotW-1] ? (~b3_d_q + 34'd1) : b3_d_q;
    b4_dprod = {33'd0, b4_dabs[32:0]} * {33'd0, b4_dabs[32:0]};
    b4_rprod = {31'd0, max_step_q} * {31'd0, max_step_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b4_valid_q <= 1'b0;
    end else if (adv) begin
      b4_valid_q <= b3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b4_dsq_q  <= b4_dprod[63:16];
      b4_rsq_q  <= b4_rprod[61:16];
      b4_d_q    <= b3_d_q;
      b4_psum_q <= b3_psum_q;
      b4_zero_q <= b3_zero_q;
    end
  end

  // ---------------- B5: quarter discriminant ----------------
  logic                 b5_valid_q;
  logic signed [QW-1:0] b5_q_q;
  logic [DotW-1:0]      b5_d_q;
  logic                 b5_zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b5_valid_q <= 1'b0;
    end else if (adv) begin
      b5_valid_q <= b4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b5_q_q    <= $signed({3'b000, b4_dsq_q}) - $signed({3'b000, b4_psum_q})
                 + $signed({5'b00000, b4_rsq_q});
      b5_d_q    <= b4_d_q;
      b5_zero_q <= b4_zero_q;
    end
  end

  // ---------------- B6: classify and clamp radicand ----------------
  logic                b6_valid_q;
  logic [2*RootW-1:0]  b6_rad_d, b6_rad_q;
  root_side_t          b6_side_d, b6_side_q;

  always_comb begin
    b6_side_d.d = b5_d_q;
    if (b5_zero_q) begin
      b6_side_d.kind = KindZeroDir;
    end else if (b5_q_q < 0) begin
      b6_side_d.kind = KindNone;
    end else if (b5_q_q <= QTangentMax) begin
      b6_side_d.kind = KindTangent;
    end else begin
      b6_side_d.kind = KindTwo;
    end
    if (b5_q_q > $signed(QW'(1) <<< QLimitLog2)) begin
      b6_rad_d = {1'b1, {(2*RootW-1){1'b0}}};
    end else begin
      b6_rad_d = {b5_q_q[QLimitLog2:0], {(2*RootW-QLimitLog2-1){1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b6_valid_q <= 1'b0;
    end else if (adv) begin
      b6_valid_q <= b5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b6_rad_q  <= b6_rad_d;
      b6_side_q <= b6_side_d;
    end
  end

  // ---------------- discriminant square-root chain ----------------
  logic [RootCells:0]               r_valid;
  logic [RootCells:0][2*RootW-1:0]  r_rad;
  logic [RootCells:0][RootW+1:0]    r_rem;
  logic [RootCells:0][RootW-1:0]    r_root;
  logic [RootCells:0][RootSW-1:0]   r_side;

  assign r_valid[0] = b6_valid_q;
  assign r_rad[0]   = b6_rad_q;
  assign r_rem[0]   = '0;
  assign r_root[0]  = '0;
  assign r_side[0]  = b6_side_q;

  for (genvar k = 0; k < RootCells; k++) begin : g_root
    msrs_sqrt_cell #(
      .RW (RootW),
      .SW (RootSW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (r_valid[k]),
      .rad_i   (r_rad[k]),
      .rem_i   (r_rem[k]),
      .root_i  (r_root[k]),
      .side_i  (r_side[k]),
      .valid_o (r_valid[k+1]),
      .rad_o   (r_rad[k+1]),
      .rem_o   (r_rem[k+1]),
      .root_o  (r_root[k+1]),
      .side_o  (r_side[k+1])
    );
  end

  assign last_valid = r_valid[RootCells];

  // ---------------- root choice and output register ----------------
  root_side_t         r_last;
  logic signed [35:0] fin_nd, fin_r1, fin_r2, fin_len;
  logic [31:0]        fin_sat;
  logic [31:0]        out_len_q;
  logic [1:0]         out_kind_q;

  always_comb begin
    r_last = root_side_t'(r_side[RootCells]);
    fin_nd = -$signed({{2{r_last.d[DotW-1]}}, r_last.d});
    fin_r1 = fin_nd + $signed({4'b0000, r_root[RootCells]});
    fin_r2 = fin_nd - $signed({4'b0000, r_root[RootCells]});
    case (r_last.kind)
      KindTangent: fin_len = fin_nd;
      KindTwo:     fin_len = (fin_r1 > 0) ? fin_r1 : fin_r2;
      default:     fin_len = '0;
    endcase
    if (fin_len > $signed(36'sh0_7FFF_FFFF)) begin
      fin_sat = 32'h7FFF_FFFF;
    end else if (fin_len < $signed(-36'sh0_8000_0000)) begin
      fin_sat = 32'h8000_0000;
    end else begin
      fin_sat = fin_len[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= last_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_len_q  <= fin_sat;
      out_kind_q <= r_last.kind;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign step_length_o = out_len_q;
  assign root_kind_o   = out_kind_q;

`ifndef NO_ASSERTIONS
  // the input side is held back only by a blocked result with a full last cell
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && last_valid))
    else $error("input stalled without a blocked output");

  // zero heading always reports a zero length
  a_zero_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (root_kind_o == KindZeroDir)) |-> (step_length_o == '0))
    else $error("zero heading with nonzero length");

  // no real root always reports a zero length
  a_no_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (root_kind_o == KindNone)) |-> (step_length_o == '0))
    else $error("missing root with nonzero length");
`endif

endmodule
`default_nettype wire

// ===== src/msrs_sqrt_cell.sv =====
// one digit step of a pipelined integer square root
`default_nettype none
module msrs_sqrt_cell
  import msrs_pkg::*;
#(
  parameter int unsigned RW = 32,
  parameter int unsigned SW = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic [2*RW-1:0] rad_i,
  input  wire logic [RW+1:0]   rem_i,
  input  wire logic [RW-1:0]   root_i,
  input  wire logic [SW-1:0]   side_i,
  output logic                 valid_o,
  output logic [2*RW-1:0]      rad_o,
  output logic [RW+1:0]        rem_o,
  output logic [RW-1:0]        root_o,
  output logic [SW-1:0]        side_o
);

  logic            valid_q;
  logic [2*RW-1:0] rad_q, rad_d;
  logic [RW+1:0]   rem_q, rem_d;
  logic [RW-1:0]   root_q, root_d;
  logic [SW-1:0]   side_q;
  logic [RW+3:0]   pair, trial, diff;
  logic            ge;

  // bring down two radicand bits and try the next root bit
  always_comb begin
    pair  = {rem_i, rad_i[2*RW-1 -: 2]};
    trial = {2'b00, root_i, 2'b01};
    diff  = pair - trial;
    ge    = (pair >= trial);
    if (ge) begin
      rem_d = diff[RW+1:0];
    end else begin
      rem_d = pair[RW+1:0];
    end
    root_d = {root_i[RW-2:0], ge};
    rad_d  = {rad_i[2*RW-3:0], 2'b00};
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

`ifndef NO_ASSERTIONS
  // partial remainder never exceeds twice the partial root
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (rem_q <= {1'b0, root_q, 1'b0}))
    else $error("sqrt remainder out of bound");
`endif

endmodule
`default_nettype wire

// ===== src/msrs_div_cell.sv =====
// one quotient bit of a pipelined restoring divider, several lanes sharing a divisor
`default_nettype none
module msrs_div_cell
  import msrs_pkg::*;
#(
  parameter int unsigned DW = 32,
  parameter int unsigned QB = 31,
  parameter int unsigned LN = 3,
  parameter int unsigned SW = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   valid_i,
  input  wire logic [DW-1:0]          div_i,
  input  wire logic [LN-1:0][DW-1:0]  rem_i,
  input  wire logic [LN-1:0][QB-1:0]  num_i,
  input  wire logic [LN-1:0][QB-1:0]  quo_i,
  input  wire logic [SW-1:0]          side_i,
  output logic                        valid_o,
  output logic [DW-1:0]               div_o,
  output logic [LN-1:0][DW-1:0]       rem_o,
  output logic [LN-1:0][QB-1:0]       num_o,
  output logic [LN-1:0][QB-1:0]       quo_o,
  output logic [SW-1:0]               side_o
);

  logic                      valid_q;
  logic [DW-1:0]             div_q;
  logic [LN-1:0][DW-1:0]     rem_q, rem_d;
  logic [LN-1:0][QB-1:0]     num_q, num_d, quo_q, quo_d;
  logic [SW-1:0]             side_q;
  logic [LN-1:0][DW:0]       part, diff;
  logic [LN-1:0]             ge;

  // shift in one numerator bit per lane and subtract when it fits
  always_comb begin
    for (int l = 0; l < LN; l++) begin
      part[l]  = {rem_i[l], num_i[l][QB-1]};
      diff[l]  = part[l] - {1'b0, div_i};
      ge[l]    = (part[l] >= {1'b0, div_i});
      rem_d[l] = ge[l] ? diff[l][DW-1:0] : part[l][DW-1:0];
      num_d[l] = {num_i[l][QB-2:0], 1'b0};
      quo_d[l] = {quo_i[l][QB-2:0], ge[l]};
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q  <= div_i;
      rem_q  <= rem_d;
      num_q  <= num_d;
      quo_q  <= quo_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;
  assign rem_o   = rem_q;
  assign num_o   = num_q;
  assign quo_o   = quo_q;
  assign side_o  = side_q;

endmodule
`default_nettype wire
